FILE: design/pm_pkg.sv
// package with constants, types and the state enum of the polynomial multiplier
`timescale 1ns / 1ps
`default_nettype none
package pm_pkg;

  localparam int MaxTerms   = 32;
  localparam int StoreDepth = 32;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CountW     = $clog2(StoreDepth + 1);
  localparam int CoefW      = 16;
  localparam int ProdW      = 2 * CoefW;
  localparam int AccW       = 40;
  localparam int DegW       = 6;

  localparam logic KindP = 1'b0;
  localparam logic KindQ = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [CoefW-1:0] coefficient;
    logic                    last;
  } pm_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_coefficient;
    logic [DegW-1:0]        degree;
    logic                   final_res;
    logic                   overflowed;
  } pm_out_t;

  typedef struct packed {
    logic                    clear;
    logic                    step;
    logic signed [CoefW-1:0] x;
  } pm_cell_ctrl_t;

  typedef enum logic {
    PmIdle,
    PmRun
  } pm_state_e;

endpackage
`default_nettype wire

FILE: design/pm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pm_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/pm_cell.sv
// one tap of the transposed convolution chain: holds a p coefficient and a partial sum
`timescale 1ns / 1ps
`default_nettype none
module pm_cell (
  input  wire logic                               clk_i,
  input  wire pm_pkg::pm_cell_ctrl_t              ctrl_i,
  input  wire logic                               load_i,
  input  wire logic                               active_i,
  input  wire logic signed [pm_pkg::CoefW-1:0]    coef_i,
  input  wire logic signed [pm_pkg::AccW-1:0]     acc_i,
  output logic      signed [pm_pkg::AccW-1:0]     acc_o
);
  import pm_pkg::*;

  logic signed [CoefW-1:0] p_q;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  acc_d, acc_q;

  assign prod = p_q * ctrl_i.x;
  assign term = active_i ? AccW'(prod) : '0;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = acc_i + term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q <= coef_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

FILE: design/polynomial_multiply.sv
// top level: coefficient intake, q buffer, cell chain and result sequencing
// each p or q coefficient comes in its own transaction; busy stays low while loading
// on the last q coefficient the block runs np+nq-1 steps (one if p is empty),
// one product coefficient a cycle, each passing the q ram read and cell accumulator registers
// busy is high from that transaction until the final result has been shown
// reset clears the intake counts and flags and the sequencer; stored coefficients are not cleared
`timescale 1ns / 1ps
`default_nettype none
module polynomial_multiply (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire pm_pkg::pm_in_t   in_item_i,
  output logic                  busy,
  output logic                  result_valid_o,
  output pm_pkg::pm_out_t       result_o
);
  import pm_pkg::*;

  pm_state_e state_q, state_d;

  logic [CountW-1:0] p_count_q, p_count_d;
  logic [CountW-1:0] q_count_q, q_count_d;
  logic              p_done_q, p_done_d;
  logic              drop_q, drop_d;

  logic [CountW-1:0] np_q, np_d;
  logic [CountW-1:0] nq_q, nq_d;
  logic [DegW-1:0]   total_q, total_d;
  logic              ovf_q, ovf_d;
  logic [DegW-1:0]   n_q, n_d;

  logic              s1_v_q, s1_zero_q, s1_final_q;
  logic [DegW-1:0]   s1_deg_q;
  logic              s2_v_q, s2_final_q;
  logic [DegW-1:0]   s2_deg_q;

  logic              accept, p_load, q_write, run_start, run_active, run_last;
  logic [DegW:0]     sum_w;
  logic [CoefW-1:0]  q_rdata;
  pm_cell_ctrl_t     ctrl;
  logic signed [AccW-1:0] acc_chain [StoreDepth+1];

  assign accept = start && !busy;
  assign busy   = (state_q != PmIdle) || s1_v_q || s2_v_q;

  // intake of coefficient transactions
  always_comb begin
    p_count_d = p_count_q;
    q_count_d = q_count_q;
    p_done_d  = p_done_q;
    drop_d    = drop_q;
    p_load    = 1'b0;
    q_write   = 1'b0;
    run_start = 1'b0;
    np_d      = np_q;
    nq_d      = nq_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    sum_w     = '0;
    if (accept) begin
      if (in_item_i.kind == KindP) begin
        if (!p_done_q) begin
          if (p_count_q < CountW'(MaxTerms)) begin
            p_load    = 1'b1;
            p_count_d = p_count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_item_i.last) begin
            p_done_d = 1'b1;
          end
        end
      end else begin
        p_done_d = 1'b1;
        if (q_count_q < CountW'(MaxTerms)) begin
          q_write   = 1'b1;
          q_count_d = q_count_q + 1'b1;
        end else begin
          drop_d = 1'b1;
        end
        if (in_item_i.last) begin
          run_start = 1'b1;
          np_d      = p_count_q;
          nq_d      = q_count_d;
          ovf_d     = drop_d;
          sum_w     = (DegW+1)'(p_count_q) + (DegW+1)'(q_count_d) - 1'b1;
          total_d   = (p_count_q == '0) ? DegW'(1) : sum_w[DegW-1:0];
          p_count_d = '0;
          q_count_d = '0;
          p_done_d  = 1'b0;
          drop_d    = 1'b0;
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      PmIdle: begin
        if (run_start) begin
          state_d = PmRun;
        end
      end
      PmRun: begin
        if (run_last) begin
          state_d = PmIdle;
        end
      end
      default: state_d = PmIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    run_active = 1'b0;
    case (state_q)
      PmIdle:  run_active = 1'b0;
      PmRun:   run_active = 1'b1;
      default: run_active = 1'b0;
    endcase
  end

  assign run_last = run_active && (n_q == total_q - 1'b1);
  assign n_d      = run_start ? '0 : (run_active ? n_q + 1'b1 : n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= PmIdle;
      p_count_q  <= '0;
      q_count_q  <= '0;
      p_done_q   <= 1'b0;
      drop_q     <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      p_count_q  <= p_count_d;
      q_count_q  <= q_count_d;
      p_done_q   <= p_done_d;
      drop_q     <= drop_d;
      s1_v_q     <= run_active;
      s2_v_q     <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    np_q       <= np_d;
    nq_q       <= nq_d;
    total_q    <= total_d;
    ovf_q      <= ovf_d;
    n_q        <= n_d;
    s1_zero_q  <= (CountW'(n_q) >= nq_q);
    s1_deg_q   <= n_q;
    s1_final_q <= run_last;
    s2_deg_q   <= s1_deg_q;
    s2_final_q <= s1_final_q;
  end

  pm_ram #(
    .Width(CoefW),
    .Depth(StoreDepth)
  ) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_write),
    .waddr_i (q_count_q[AddrW-1:0]),
    .wdata_i (in_item_i.coefficient),
    .re_i    (run_active),
    .raddr_i (n_q[AddrW-1:0]),
    .rdata_o (q_rdata)
  );

  assign ctrl.clear = run_start;
  assign ctrl.step  = s1_v_q;
  assign ctrl.x     = s1_zero_q ? '0 : q_rdata;

  assign acc_chain[StoreDepth] = '0;

  for (genvar i = 0; i < StoreDepth; i++) begin : g_cell
    pm_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .load_i   (p_load && (p_count_q[AddrW-1:0] == AddrW'(i))),
      .active_i (CountW'(i) < np_q),
      .coef_i   (in_item_i.coefficient),
      .acc_i    (acc_chain[i+1]),
      .acc_o    (acc_chain[i])
    );
  end

  assign result_valid_o               = s2_v_q;
  assign result_o.product_coefficient = acc_chain[0];
  assign result_o.degree              = s2_deg_q;
  assign result_o.final_res           = s2_final_q;
  assign result_o.overflowed          = ovf_q;

endmodule
`default_nettype wire
